// File: sv/cle_pkg.sv
// Shared types and constants for the console line editor with history.
// No dependencies; cle_ctrl, cle_dp and the top level import this package.
package cle_pkg;

    typedef enum logic [2:0] {
        KIND_ECHO   = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_RECALL = 3'd2,
        KIND_COMMIT = 3'd3,
        KIND_EMPTY  = 3'd4,
        KIND_FULL   = 3'd5,
        KIND_STORED = 3'd6
    } kind_t;

    typedef enum logic {
        OP_CONSOLE = 1'b0,
        OP_READ    = 1'b1
    } op_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       packet_start;
        logic [1:0] read_slot;
        logic [6:0] read_position;
    } in_word_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic [6:0] char_count;
        logic [1:0] slot;
        logic       last;
    } out_word_t;

    localparam logic [7:0] CH_CTRL_D = 8'h04;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRKT  = 8'h5B;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;

    typedef enum logic [1:0] {
        ESC_NONE    = 2'd0,
        ESC_SEEN    = 2'd1,
        ESC_BRACKET = 2'd2
    } esc_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EMIT,
        ACT_READ,
        ACT_COMMIT,
        ACT_RECALL
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_ERASE,
        S_RECALL,
        S_COPY_C,
        S_COPY_R
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic emit_stored;
        logic emit_erase;
        logic emit_recall;
        logic copy_c;
        logic copy_r;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic out_free;
        logic line_busy;
        logic copy_done;
    } stat_t;

endpackage

// File: sv/cle_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: sv/cle_ctrl.sv
// Controller state machine of the line editor: sequences decode, result
// emission and line copies. Depends on cle_pkg.
module cle_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cle_pkg::stat_t stat,
    output cle_pkg::cmd_t  cmd
);
    import cle_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (stat.act)
                    ACT_EMIT:   if (stat.out_free) state_next = S_IDLE;
                    ACT_COMMIT: if (stat.out_free) state_next = S_COPY_C;
                    ACT_READ:   state_next = S_READ;
                    ACT_RECALL: state_next = S_ERASE;
                    default:    state_next = S_IDLE;
                endcase
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERASE:
            begin
                if (!stat.line_busy || stat.out_free)
                begin
                    state_next = S_RECALL;
                end
            end
            S_RECALL:
            begin
                if (stat.out_free)
                begin
                    state_next = S_COPY_R;
                end
            end
            S_COPY_C, S_COPY_R:
            begin
                if (stat.copy_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.latch = in_valid;
            end
            S_EXEC:
            begin
                case (stat.act)
                    ACT_EMIT, ACT_COMMIT: cmd.exec = stat.out_free;
                    default:              cmd.exec = 1'b1;
                endcase
            end
            S_READ:   cmd.emit_stored = stat.out_free;
            S_ERASE:  cmd.emit_erase  = stat.line_busy && stat.out_free;
            S_RECALL: cmd.emit_recall = stat.out_free;
            S_COPY_C: cmd.copy_c      = 1'b1;
            S_COPY_R: cmd.copy_r      = 1'b1;
            default:  cmd             = '0;
        endcase
    end
endmodule

// File: sv/cle_dp.sv
// Datapath of the line editor: editor state, history lengths, edit and
// history RAMs, copy counter and output register. Depends on cle_pkg, cle_ram.
module cle_dp #(
    parameter int LINE_BYTES    = 128,
    parameter int HISTORY_SLOTS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cle_pkg::in_word_t   in_data,
    input  cle_pkg::cmd_t       cmd,
    output cle_pkg::stat_t      stat,
    output logic                out_valid,
    input  logic                out_ready,
    output cle_pkg::out_word_t  out_data
);
    import cle_pkg::*;

    localparam int LL_W       = $clog2(LINE_BYTES);
    localparam int SL_W       = $clog2(HISTORY_SLOTS);
    localparam int ES_W       = $clog2(HISTORY_SLOTS + 1);
    localparam int HIST_DEPTH = HISTORY_SLOTS * LINE_BYTES;
    localparam int HA_W       = $clog2(HIST_DEPTH);
    localparam logic [LL_W-1:0] LEN_MAX = LL_W'(LINE_BYTES - 1);

    in_word_t          in_reg;
    logic [LL_W-1:0]   len_reg, len_next;
    esc_t              esc_reg, esc_next;
    logic              after_enter_reg, after_enter_next;
    logic              skip_reg, skip_next;
    logic [ES_W-1:0]   entries_reg, entries_next;
    logic [SL_W-1:0]   wslot_reg, wslot_next;
    logic [SL_W-1:0]   ridx_reg, ridx_next;
    logic [LL_W-1:0]   hist_len_reg [HISTORY_SLOTS];
    logic              hist_len_we;
    logic [LL_W-1:0]   copy_len_reg, copy_len_next;
    logic [SL_W-1:0]   copy_slot_reg, copy_slot_next;
    logic [LL_W-1:0]   cnt_reg, cnt_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg, out_next;

    logic              edit_we, edit_re;
    logic [LL_W-1:0]   edit_waddr;
    logic [7:0]        edit_wdata, edit_rdata;
    logic              hist_we, hist_re;
    logic [HA_W-1:0]   hist_waddr, hist_raddr;
    logic [7:0]        hist_rdata;

    act_t              act;
    logic              out_free;
    logic [7:0]        c;
    logic              skip_eff;
    logic [SL_W-1:0]   newest;
    logic [SL_W:0]     ridx_inc;

    assign out_free   = !out_valid_reg || out_ready;
    assign c          = in_reg.rx_byte;
    assign skip_eff   = skip_reg && !in_reg.packet_start;
    assign newest     = SL_W'(entries_reg - ES_W'(1));
    assign ridx_inc   = {1'b0, ridx_reg} + (SL_W + 1)'(1);

    // Classify the held word.
    always_comb
    begin
        act = ACT_NONE;
        if (in_reg.op == OP_READ)
        begin
            act = ACT_READ;
        end
        else if (skip_eff || (after_enter_reg && c == CH_LF) || c == CH_ESC
                 || c == CH_CTRL_D || esc_reg == ESC_SEEN)
        begin
            act = ACT_NONE;
        end
        else if (esc_reg == ESC_BRACKET)
        begin
            if ((c == CH_UP || c == CH_DOWN) && entries_reg != '0)
            begin
                act = ACT_RECALL;
            end
        end
        else if (c == CH_CR && len_reg != '0)
        begin
            act = ACT_COMMIT;
        end
        else
        begin
            act = ACT_EMIT;
        end
    end

    always_comb
    begin
        len_next         = len_reg;
        esc_next         = esc_reg;
        after_enter_next = after_enter_reg;
        skip_next        = skip_reg;
        entries_next     = entries_reg;
        wslot_next       = wslot_reg;
        ridx_next        = ridx_reg;
        hist_len_we      = 1'b0;
        copy_len_next    = copy_len_reg;
        copy_slot_next   = copy_slot_reg;
        cnt_next         = cnt_reg;
        rd_ok_next       = rd_ok_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_next         = out_reg;
        edit_we          = 1'b0;
        edit_waddr       = len_reg;
        edit_wdata       = c;
        edit_re          = 1'b0;
        hist_we          = 1'b0;
        hist_re          = 1'b0;
        hist_waddr = HA_W'(HA_W'(copy_slot_reg) * HA_W'(LINE_BYTES) + HA_W'(cnt_reg - LL_W'(1)));
        hist_raddr = HA_W'(HA_W'(in_reg.read_slot) * HA_W'(LINE_BYTES)
                     + HA_W'(in_reg.read_position));

        if (cmd.exec)
        begin
            // clear the output word only when this word emits; else hold a waiting result
            if (act == ACT_EMIT || act == ACT_COMMIT)
            begin
                out_next      = '0;
                out_next.last = 1'b1;
            end
            if (in_reg.op == OP_READ)
            begin
                hist_re    = 1'b1;
                rd_ok_next = (32'(in_reg.read_slot) < HISTORY_SLOTS)
                          && (32'(in_reg.read_position) < LINE_BYTES);
            end
            else
            begin
                if (in_reg.packet_start)
                begin
                    skip_next = 1'b0;
                end
                if (skip_eff)
                begin
                    // drop the rest of the packet
                end
                else if (after_enter_reg && c == CH_LF)
                begin
                    skip_next = 1'b1;
                end
                else if (c == CH_ESC)
                begin
                    esc_next = ESC_SEEN;
                end
                else if (c == CH_CTRL_D)
                begin
                    // ignored
                end
                else if (esc_reg == ESC_SEEN)
                begin
                    esc_next = (c == CH_LBRKT) ? ESC_BRACKET : ESC_NONE;
                end
                else if (esc_reg == ESC_BRACKET)
                begin
                    esc_next = ESC_NONE;
                    if (act == ACT_RECALL)
                    begin
                        if (c == CH_UP)
                        begin
                            ridx_next = (ridx_reg == '0) ? newest : ridx_reg - SL_W'(1);
                        end
                        else
                        begin
                            ridx_next = (ridx_inc > {1'b0, newest}) ? '0 : SL_W'(ridx_inc);
                        end
                    end
                end
                else if (c == CH_CR)
                begin
                    after_enter_next = 1'b1;
                    if (len_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        out_next.kind  = KIND_EMPTY;
                    end
                    else
                    begin
                        out_valid_next      = 1'b1;
                        out_next.kind       = KIND_COMMIT;
                        out_next.char_count = 7'(len_reg);
                        out_next.slot       = 2'(wslot_reg);
                        hist_len_we         = 1'b1;
                        copy_len_next       = len_reg;
                        copy_slot_next      = wslot_reg;
                        cnt_next            = '0;
                        if (32'(entries_reg) < HISTORY_SLOTS)
                        begin
                            entries_next = entries_reg + ES_W'(1);
                        end
                        wslot_next = (32'(wslot_reg) == HISTORY_SLOTS - 1) ? '0
                                   : wslot_reg + SL_W'(1);
                        ridx_next  = wslot_next;
                        len_next   = '0;
                    end
                end
                else if (c == CH_BS)
                begin
                    out_valid_next = 1'b1;
                    if (len_reg != '0)
                    begin
                        len_next            = len_reg - LL_W'(1);
                        out_next.kind       = KIND_ERASE;
                        out_next.char_count = 7'd1;
                    end
                    else
                    begin
                        out_next.kind = KIND_EMPTY;
                    end
                end
                else if (len_reg < LEN_MAX)
                begin
                    edit_we          = 1'b1;
                    len_next         = len_reg + LL_W'(1);
                    after_enter_next = 1'b0;
                    out_valid_next   = 1'b1;
                    out_next.kind    = KIND_ECHO;
                    out_next.out_byte = c;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_next.kind  = KIND_FULL;
                end
            end
        end

        if (cmd.emit_stored)
        begin
            out_valid_next    = 1'b1;
            out_next          = '0;
            out_next.kind     = KIND_STORED;
            out_next.out_byte = rd_ok_reg ? hist_rdata : 8'd0;
            out_next.last     = 1'b1;
        end

        if (cmd.emit_erase)
        begin
            out_valid_next      = 1'b1;
            out_next            = '0;
            out_next.kind       = KIND_ERASE;
            out_next.char_count = 7'(len_reg);
        end

        if (cmd.emit_recall)
        begin
            len_next            = hist_len_reg[ridx_reg];
            copy_len_next       = hist_len_reg[ridx_reg];
            copy_slot_next      = ridx_reg;
            cnt_next            = '0;
            out_valid_next      = 1'b1;
            out_next            = '0;
            out_next.kind       = KIND_RECALL;
            out_next.char_count = 7'(hist_len_reg[ridx_reg]);
            out_next.slot       = 2'(ridx_reg);
            out_next.last       = 1'b1;
        end

        // Copy: read position cnt and write position cnt-1, from the registered read data.
        if (cmd.copy_c)
        begin
            edit_re = cnt_reg != copy_len_reg;
            hist_we = cnt_reg != '0;
            if (cnt_reg != copy_len_reg)
            begin
                cnt_next = cnt_reg + LL_W'(1);
            end
        end

        if (cmd.copy_r)
        begin
            hist_re    = cnt_reg != copy_len_reg;
            hist_raddr = HA_W'(HA_W'(copy_slot_reg) * HA_W'(LINE_BYTES) + HA_W'(cnt_reg));
            edit_we    = cnt_reg != '0;
            edit_waddr = cnt_reg - LL_W'(1);
            edit_wdata = hist_rdata;
            if (cnt_reg != copy_len_reg)
            begin
                cnt_next = cnt_reg + LL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            esc_reg         <= ESC_NONE;
            after_enter_reg <= 1'b0;
            skip_reg        <= 1'b0;
            entries_reg     <= '0;
            wslot_reg       <= '0;
            ridx_reg        <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < HISTORY_SLOTS; i++)
            begin
                hist_len_reg[i] <= '0;
            end
        end
        else
        begin
            len_reg         <= len_next;
            esc_reg         <= esc_next;
            after_enter_reg <= after_enter_next;
            skip_reg        <= skip_next;
            entries_reg     <= entries_next;
            wslot_reg       <= wslot_next;
            ridx_reg        <= ridx_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
            if (hist_len_we)
            begin
                hist_len_reg[wslot_reg] <= len_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            in_reg <= in_data;
        end
        copy_len_reg  <= copy_len_next;
        copy_slot_reg <= copy_slot_next;
        rd_ok_reg     <= rd_ok_next;
        out_reg       <= out_next;
    end

    cle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_edit_ram (
        .clk     (clk),
        .wr_en   (edit_we),
        .wr_addr (edit_waddr),
        .wr_data (edit_wdata),
        .rd_en   (edit_re),
        .rd_addr (cnt_reg),
        .rd_data (edit_rdata)
    );

    cle_ram #(
        .WIDTH (8),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (edit_rdata),
        .rd_en   (hist_re),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    assign stat.act       = act;
    assign stat.out_free  = out_free;
    assign stat.line_busy = len_reg != '0;
    assign stat.copy_done = cnt_reg == copy_len_reg;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_reg;
endmodule

// File: sv/console_line_editor_history.sv
// Console line editor with a ring of stored command lines.
// Depends on cle_pkg, cle_ctrl, cle_dp (which holds the cle_ram instances).
//
// Usage:
//   in_valid/in_ready/in_data carry one word: a console byte (op 0) or a
//   request to read one stored history byte (op 1). out_valid/out_ready/
//   out_data carry result words; last marks the final result of an input.
//   An input gives zero, one or two results.
//   Timing: a word is taken in IDLE and decoded the next cycle; a result
//   goes to the output register. A history read passes through the
//   registered RAM read. A commit or a recall copies the line one byte per
//   cycle through the RAM ports before the next word is taken.
//   The output register lets a new word enter while a result is still
//   waiting; a stalled receiver holds the block when a further result must
//   be emitted. Reset clears the editor state and history lengths; the line
//   RAMs are not cleared. The edit RAM is never read before being written,
//   but a history read request may return a byte that was never written.
module console_line_editor_history #(
    parameter int LINE_BYTES    = 128,
    parameter int HISTORY_SLOTS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cle_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cle_pkg::out_word_t out_data
);
    import cle_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    cle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cle_dp #(
        .LINE_BYTES    (LINE_BYTES),
        .HISTORY_SLOTS (HISTORY_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );
endmodule
